// ===== sv/rgb_median_filter_3x3_top_assert.svh =====
// rgb_median_filter_3x3_top_assert.svh: assertion macros for the RGB median filter
`ifndef RGB_MEDIAN_FILTER_3X3_TOP_ASSERT_SVH
`define RGB_MEDIAN_FILTER_3X3_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define RMF_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
`define RMF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define RMF_ASSERT_SAME(name, clk, rst, ante, cons)
`define RMF_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== sv/rmf_pkg.sv =====
`timescale 1ns / 1ps
// rmf_pkg: shared types and constants of the RGB 3x3 median filter
package rmf_pkg;
   localparam int CHANNELS   = 3;
   localparam int LEVEL_BITS = 8;
   localparam int DIM_BITS   = 10;
   localparam int ROW_BITS   = 9;
   localparam int ROWS_MAX   = 512;
   localparam int DIM_MIN    = 3;
   localparam int DIM_RESET  = 512;
   localparam int SLOTS      = 3;

   localparam logic MODE_FLUSH = 1'b1;

   typedef logic [LEVEL_BITS-1:0]                level_type;
   typedef logic [CHANNELS-1:0][LEVEL_BITS-1:0] pixel_type;
   typedef logic [DIM_BITS-1:0]                  hgt_type;
   typedef logic [ROW_BITS-1:0]                  row_type;
   typedef logic [1:0]                           slot_type;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_MAX_LEVEL    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic      mode;
      level_type red_in;
      level_type green_in;
      level_type blue_in;
   } req_payload_type;

   typedef struct packed {
      level_type red_out;
      level_type green_out;
      level_type blue_out;
      logic      frame_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]          index;
      logic [DIM_BITS-1:0] wdata;
   } csr_payload_type;
endpackage

// ===== sv/rmf_stream_if.sv =====
`timescale 1ns / 1ps
// rmf_stream_if: valid/ready channel carrying one payload beat
interface rmf_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/rgb_median_filter_3x3_top.sv =====
`timescale 1ns / 1ps
// RGB 3x3 median filter: three rotating line stores, 3x3 window, sorting-network pipeline.
// One beat per cycle on each side unless rsp_chan stalls; line store reads are registered.
// A result leaves rsp_chan once the beat that releases it has passed the line read, window
// shift, column sort, and merge and clamp into the output register; stalls can hold it.
// Reset (synchronous, active high) clears positions, pipeline and CSRs to defaults;
// line stores are not cleared and no clearing pass runs, so beats are taken right away.
`include "rgb_median_filter_3x3_top_assert.svh"
module rgb_median_filter_3x3_top import rmf_pkg::*; #(
   parameter int MAX_WIDTH = 512
) (
   input  logic         clock,
   input  logic         reset,
   rmf_stream_if.sink   req_chan,
   rmf_stream_if.source rsp_chan,
   rmf_stream_if.sink   csr_chan
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int PND_W   = $clog2(MAX_WIDTH + 3);
   localparam int W_RESET = (MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET;

   typedef logic [COL_W-1:0] col_type;
   typedef logic [WID_W-1:0] wid_type;
   typedef logic [PND_W-1:0] pnd_type;

   function automatic slot_type slot_inc(input slot_type s);
      return (s == slot_type'(SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic level_type min2(input level_type a, input level_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic level_type max2(input level_type a, input level_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic level_type med3(input level_type a, input level_type b,
                                      input level_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // ---------------- CSRs ----------------
   wid_type   eff_w_ff;
   hgt_type   eff_h_ff;
   level_type max_level_ff;
   logic      [DIM_BITS-1:0] csr_data;

   assign csr_chan.ready = 1'b1;
   assign csr_data       = csr_chan.payload.wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff     <= wid_type'(W_RESET);
         eff_h_ff     <= hgt_type'(DIM_RESET);
         max_level_ff <= '1;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.payload.index))
            CSR_FRAME_WIDTH: begin
               if (csr_data < hgt_type'(DIM_MIN))
                  eff_w_ff <= wid_type'(DIM_MIN);
               else if (int'(csr_data) > MAX_WIDTH)
                  eff_w_ff <= wid_type'(MAX_WIDTH);
               else
                  eff_w_ff <= wid_type'(csr_data);
            end
            CSR_FRAME_HEIGHT: begin
               if (csr_data < hgt_type'(DIM_MIN))
                  eff_h_ff <= hgt_type'(DIM_MIN);
               else if (int'(csr_data) > ROWS_MAX)
                  eff_h_ff <= hgt_type'(ROWS_MAX);
               else
                  eff_h_ff <= csr_data;
            end
            CSR_MAX_LEVEL: begin
               max_level_ff <= csr_data[LEVEL_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- pipeline flow ----------------
   logic rsp_valid_ff, c_valid_ff, b_valid_ff, a_valid_ff;
   logic d_open, c_open, b_open, a_open;
   logic a_adv, b_move, c_move, accept, a_take;

   assign d_open = !rsp_valid_ff || rsp_chan.ready;
   assign c_open = !c_valid_ff || d_open;
   assign b_open = !b_valid_ff || c_open;
   assign a_open = !a_valid_ff || b_open;
   assign a_adv  = a_valid_ff && b_open;
   assign b_move = b_valid_ff && c_open;
   assign c_move = c_valid_ff && d_open;

   assign req_chan.ready = a_open;
   assign accept         = req_chan.valid && a_open;

   // ---------------- positions ----------------
   col_type  in_col_ff, out_col_ff, in_col_in, out_col_in;
   row_type  in_row_ff, out_row_ff, in_row_in, out_row_in;
   slot_type in_slot_ff, out_slot_ff, in_slot_in, out_slot_in;
   pnd_type  pending_ff, pending_in;
   wid_type  in_col_inc, out_col_inc;
   hgt_type  in_row_inc, out_row_inc;
   logic     is_flush, px_emit, fl_emit, item_emit, out_edge, out_end;
   pixel_type req_pix;

   assign is_flush   = (req_chan.payload.mode == MODE_FLUSH);
   assign req_pix[0] = req_chan.payload.red_in;
   assign req_pix[1] = req_chan.payload.green_in;
   assign req_pix[2] = req_chan.payload.blue_in;

   assign in_col_inc  = wid_type'(in_col_ff) + 1'b1;
   assign out_col_inc = wid_type'(out_col_ff) + 1'b1;
   assign in_row_inc  = hgt_type'(in_row_ff) + 1'b1;
   assign out_row_inc = hgt_type'(out_row_ff) + 1'b1;

   // a pixel releases a result once the window below its target row is complete
   assign px_emit   = pending_ff >= (pnd_type'(eff_w_ff) + 1'b1);
   assign fl_emit   = (pending_ff != '0) && (in_row_ff == '0) && (in_col_ff == '0);
   assign item_emit = is_flush ? fl_emit : px_emit;
   assign a_take    = accept && (!is_flush || fl_emit);

   assign out_edge = (out_row_ff == '0) || (out_row_inc >= eff_h_ff) ||
                     (out_col_ff == '0) || (out_col_inc >= eff_w_ff);
   assign out_end  = (out_row_inc == eff_h_ff) && (out_col_inc == eff_w_ff);

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      pending_in  = pending_ff;
      if (accept && !is_flush) begin
         if (in_col_inc >= eff_w_ff) begin
            in_col_in  = '0;
            in_slot_in = slot_inc(in_slot_ff);
            in_row_in  = (in_row_inc >= eff_h_ff) ? '0 : row_type'(in_row_inc);
         end else begin
            in_col_in = col_type'(in_col_inc);
         end
      end
      if (accept && item_emit) begin
         if (out_col_inc >= eff_w_ff) begin
            out_col_in  = '0;
            out_slot_in = slot_inc(out_slot_ff);
            out_row_in  = (out_row_inc >= eff_h_ff) ? '0 : row_type'(out_row_inc);
         end else begin
            out_col_in = col_type'(out_col_inc);
         end
      end
      if (accept && !is_flush && !px_emit)
         pending_in = pending_ff + 1'b1;
      else if (accept && is_flush && fl_emit)
         pending_in = pending_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         pending_ff  <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
         pending_ff  <= pending_in;
      end
   end

   // ---------------- line stores ----------------
   logic [SLOTS-1:0] mem_we, mem_re;
   col_type          rd_addr;
   pixel_type        rd_ff [SLOTS];

   assign rd_addr = is_flush ? out_col_ff : in_col_ff;

   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         mem_we[k] = accept && !is_flush && (in_slot_ff == slot_type'(k));
         mem_re[k] = a_take && (is_flush || (in_slot_ff != slot_type'(k)));
      end
   end

   for (genvar k = 0; k < SLOTS; k++) begin : g_line
      pixel_type line_mem [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (mem_we[k])
            line_mem[in_col_ff] <= req_pix;
         if (mem_re[k])
            rd_ff[k] <= line_mem[rd_addr];
      end
   end

   // ---------------- stage A: line read ----------------
   logic      a_flush_ff, a_emit_ff, a_edge_ff, a_end_ff, a_valid_in;
   slot_type  a_slot_ff;
   pixel_type a_pix_ff;

   assign a_valid_in = a_take ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset)
         a_valid_ff <= 1'b0;
      else
         a_valid_ff <= a_valid_in;
      if (a_take) begin
         a_flush_ff <= is_flush;
         a_emit_ff  <= item_emit;
         a_edge_ff  <= out_edge;
         a_end_ff   <= out_end;
         a_slot_ff  <= is_flush ? out_slot_ff : in_slot_ff;
         a_pix_ff   <= req_pix;
      end
   end

   // ---------------- stage B: window shift ----------------
   // win_ff[col][row], row 0 is the oldest line; column 2 takes the newest pixel
   pixel_type win_ff [3][3];
   pixel_type b_line_ff;
   logic      b_flush_ff, b_edge_ff, b_end_ff, b_valid_in;
   slot_type  slot_top, slot_mid;

   assign slot_top   = slot_inc(a_slot_ff);
   assign slot_mid   = slot_inc(slot_top);
   assign b_valid_in = a_adv ? a_emit_ff : (b_move ? 1'b0 : b_valid_ff);

   always_ff @(posedge clock) begin
      if (reset)
         b_valid_ff <= 1'b0;
      else
         b_valid_ff <= b_valid_in;
      if (a_adv) begin
         b_flush_ff <= a_flush_ff;
         b_edge_ff  <= a_edge_ff;
         b_end_ff   <= a_end_ff;
         b_line_ff  <= rd_ff[a_slot_ff];
      end
      if (a_adv && !a_flush_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[0][r] <= win_ff[1][r];
            win_ff[1][r] <= win_ff[2][r];
         end
         win_ff[2][0] <= rd_ff[slot_top];
         win_ff[2][1] <= rd_ff[slot_mid];
         win_ff[2][2] <= a_pix_ff;
      end
   end

   // ---------------- stage C: column sort ----------------
   level_type c_sort_ff [CHANNELS][3][3];
   level_type c_sort_in [CHANNELS][3][3];
   pixel_type c_edge_ff;
   logic      c_use_edge_ff, c_end_ff, c_valid_in;

   always_comb begin
      level_type x, y, z;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int col = 0; col < 3; col++) begin
            x = win_ff[col][0][ch];
            y = win_ff[col][1][ch];
            z = win_ff[col][2][ch];
            c_sort_in[ch][col][0] = min2(min2(x, y), z);
            c_sort_in[ch][col][1] = med3(x, y, z);
            c_sort_in[ch][col][2] = max2(max2(x, y), z);
         end
      end
   end

   assign c_valid_in = b_move ? 1'b1 : (c_move ? 1'b0 : c_valid_ff);

   always_ff @(posedge clock) begin
      if (reset)
         c_valid_ff <= 1'b0;
      else
         c_valid_ff <= c_valid_in;
      if (b_move) begin
         c_sort_ff     <= c_sort_in;
         c_use_edge_ff <= b_edge_ff;
         c_end_ff      <= b_end_ff;
         // border pixels pass through: center of the window, or the line read for a flush
         c_edge_ff     <= b_flush_ff ? b_line_ff : win_ff[1][1];
      end
   end

   // ---------------- stage D: merge, clamp, output register ----------------
   pixel_type       res;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            rsp_valid_in;

   always_comb begin
      level_type lo_max, mid_med, hi_min, med, v;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         lo_max  = max2(max2(c_sort_ff[ch][0][0], c_sort_ff[ch][1][0]), c_sort_ff[ch][2][0]);
         mid_med = med3(c_sort_ff[ch][0][1], c_sort_ff[ch][1][1], c_sort_ff[ch][2][1]);
         hi_min  = min2(min2(c_sort_ff[ch][0][2], c_sort_ff[ch][1][2]), c_sort_ff[ch][2][2]);
         med     = med3(lo_max, mid_med, hi_min);
         v       = c_use_edge_ff ? c_edge_ff[ch] : med;
         res[ch] = (v > max_level_ff) ? max_level_ff : v;
      end
   end

   always_comb begin
      rsp_data_in.red_out   = res[0];
      rsp_data_in.green_out = res[1];
      rsp_data_in.blue_out  = res[2];
      rsp_data_in.frame_end = c_end_ff;
   end

   assign rsp_valid_in = c_move ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
      if (c_move)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // ---------------- checks ----------------
   logic pipe_full, slots_ok;

   assign pipe_full = a_valid_ff && b_valid_ff && c_valid_ff && rsp_valid_ff;
   assign slots_ok  = (in_slot_ff != slot_type'(SLOTS)) && (out_slot_ff != slot_type'(SLOTS));

   `RMF_ASSERT_SAME(ast_stall_only_when_full, clock, reset, !req_chan.ready, pipe_full)
   `RMF_ASSERT_NEXT(ast_sorted_reaches_output, clock, reset, c_valid_ff && d_open, rsp_valid_ff)
   `RMF_ASSERT_SAME(ast_slots_in_range, clock, reset, 1'b1, slots_ok)

endmodule
